>>> hdl/pgr_pkg.sv
// ----------------------------------------------------------------------------
// pgr_pkg
// shared types and constants for the page replacement block
// ----------------------------------------------------------------------------
package pgr_pkg;

    // policy codes held in the policy register
    localparam logic [1:0] POLICY_FIFO = 2'd0;
    localparam logic [1:0] POLICY_LRU  = 2'd1;
    localparam logic [1:0] POLICY_SC   = 2'd2;

    // register indexes on the configuration port
    localparam logic REG_POLICY   = 1'b0;
    localparam logic REG_CAPACITY = 1'b1;

    // field widths fixed by the stream format
    localparam int PAGE_W   = 21;
    localparam int MODE_W   = 2;
    localparam int CAP_W    = 5;
    localparam int COST_W   = 10;
    localparam int TOTAL_W  = 48;
    localparam int FAULTS_W = 32;

    localparam logic [COST_W-1:0] FAULT_COST = 10'd100;
    localparam logic [COST_W-1:0] DIRTY_COST = 10'd500;
    localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;

    // broadcast control for every cell of the chain
    typedef struct packed {
        logic en;         // update cycle
        logic wr;         // access is a write
        logic hit;        // page found somewhere in the chain
        logic remove;     // one entry leaves the order this cycle
        logic append;     // new entry goes to the first free cell
        logic sc_mark;    // second chance hit, set reference bit
        logic sc_find;    // second chance eviction with an unreferenced page
        logic sc_clear;   // second chance eviction, clear passed reference bits
        logic new_dirty;  // dirty bit of the entry loaded at the tail
        logic new_ref;    // reference bit of the entry loaded at the tail
    } cell_ctrl_t;

endpackage

>>> hdl/pgr_cell.sv
// ----------------------------------------------------------------------------
// pgr_cell
// one frame of the ordered chain: tag compare, search links, shift and load
// ----------------------------------------------------------------------------
module pgr_cell #(
    parameter int PAGE_BITS = 21
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pgr_pkg::cell_ctrl_t   ctrl,
    input  logic [PAGE_BITS-1:0]  new_page,
    // neighbor above (younger entry)
    input  logic                  up_valid,
    input  logic [PAGE_BITS-1:0]  up_page,
    input  logic                  up_dirty,
    input  logic                  up_refd,
    // neighbor below (older entry)
    input  logic                  prev_valid,
    // search links, from older to younger
    input  logic                  hit_in,
    output logic                  hit_out,
    input  logic                  vic_in,
    output logic                  vic_out,
    input  logic                  after_in,
    output logic                  after_out,
    output logic                  hit_here,
    output logic                  rm_here,
    // stored entry
    output logic                  valid,
    output logic [PAGE_BITS-1:0]  page,
    output logic                  dirty,
    output logic                  refd
);

    logic                 valid_reg, valid_next;
    logic [PAGE_BITS-1:0] page_reg, page_next;
    logic                 dirty_reg, dirty_next;
    logic                 refd_reg, refd_next;
    logic                 match;
    logic                 unref;
    logic                 vic_here;
    logic                 at_after;
    logic                 tail_here;
    logic                 free_here;

    assign match     = valid_reg && (page_reg == new_page);
    assign hit_here  = match && !hit_in;
    assign hit_out   = hit_in || match;
    assign unref     = valid_reg && !refd_reg;
    assign vic_here  = unref && !vic_in;
    assign vic_out   = vic_in || unref;
    assign rm_here   = ctrl.remove && ((ctrl.hit && hit_here) || (ctrl.sc_find && vic_here));
    assign at_after  = after_in || rm_here;
    assign after_out = at_after;
    assign tail_here = valid_reg && !up_valid;
    assign free_here = !valid_reg && prev_valid;

    always_comb
    begin
        valid_next = valid_reg;
        page_next  = page_reg;
        dirty_next = dirty_reg;
        refd_next  = refd_reg;
        if (ctrl.en)
        begin
            if (ctrl.remove)
            begin
                if (tail_here)
                begin
                    page_next  = new_page;
                    dirty_next = ctrl.new_dirty;
                    refd_next  = ctrl.new_ref;
                end
                else if (at_after)
                begin
                    valid_next = up_valid;
                    page_next  = up_page;
                    dirty_next = up_dirty;
                    // every reference bit is cleared when no page was unreferenced
                    refd_next  = (ctrl.sc_clear && !ctrl.sc_find) ? 1'b0 : up_refd;
                end
                else if (valid_reg && ctrl.sc_clear)
                begin
                    refd_next = 1'b0;
                end
            end
            else if (ctrl.append)
            begin
                if (free_here)
                begin
                    valid_next = 1'b1;
                    page_next  = new_page;
                    dirty_next = ctrl.wr;
                    refd_next  = 1'b0;
                end
            end
            else if (ctrl.hit && hit_here)
            begin
                dirty_next = dirty_reg || ctrl.wr;
                if (ctrl.sc_mark)
                begin
                    refd_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            dirty_reg <= 1'b0;
            refd_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            dirty_reg <= dirty_next;
            refd_reg  <= refd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
    end

    assign valid = valid_reg;
    assign page  = page_reg;
    assign dirty = dirty_reg;
    assign refd  = refd_reg;

endmodule

>>> hdl/page_replacement_policy.sv
// ----------------------------------------------------------------------------
// page_replacement_policy
// page frame tracker with FIFO, LRU and second chance replacement
// ----------------------------------------------------------------------------
// an access is captured into the input registers; its update cycle then writes the result register
// a new access is taken only once the last one has had its update cycle, in which all
//   frame cells compare, search and shift together
// a stalled result holds the update cycle of the next access until it is taken
// reset: all frames empty, totals zero, policy FIFO, capacity 16
// ----------------------------------------------------------------------------
module page_replacement_policy #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 21
) (
    input  logic         clk,
    input  logic         rst_n,
    // access stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // [20:0] page_number, [23:21] zero
    input  logic         s_tuser,   // [0] is_write
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata,   // [0] hit, [1] evicted_valid, [22:2] evicted_page,
                                    // [23] evicted_dirty, [33:24] access_cost,
                                    // [81:34] total_cost, [113:82] total_faults,
                                    // [119:114] zero
    // configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int PW  = pgr_pkg::PAGE_W;
    localparam int CW  = $clog2(FRAMES + 1);
    localparam int KW  = (CW > pgr_pkg::CAP_W) ? CW : pgr_pkg::CAP_W;
    localparam int TW  = pgr_pkg::TOTAL_W;
    localparam int FW  = pgr_pkg::FAULTS_W;
    localparam int OW  = 3 + PW + pgr_pkg::COST_W + TW + FW;

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    logic [pgr_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [pgr_pkg::CAP_W-1:0]  cap_reg, cap_next;
    logic                       cfg_wr;
    logic                       cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = paddr[2];

    always_comb
    begin
        mode_next = mode_reg;
        cap_next  = cap_reg;
        if (cfg_wr)
        begin
            case (cfg_sel)
                pgr_pkg::REG_POLICY:   mode_next = pwdata[pgr_pkg::MODE_W-1:0];
                pgr_pkg::REG_CAPACITY: cap_next  = pwdata[pgr_pkg::CAP_W-1:0];
                default:               mode_next = mode_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            pgr_pkg::REG_POLICY:   prdata = {{(32 - pgr_pkg::MODE_W){1'b0}}, mode_reg};
            pgr_pkg::REG_CAPACITY: prdata = {{(32 - pgr_pkg::CAP_W){1'b0}}, cap_reg};
            default:               prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // input capture
    // ------------------------------------------------------------------------
    logic                 busy_reg, busy_next;
    logic [PAGE_BITS-1:0] in_page;
    logic [PAGE_BITS-1:0] page_reg, page_next;
    logic                 wr_reg, wr_next;
    logic                 s_fire;
    logic                 work;
    logic                 out_valid_reg, out_valid_next;

    // only the low page bits take part in the compare
    generate
        if (PAGE_BITS == PW)
        begin : g_in_eq
            assign in_page = s_tdata[PW-1:0];
        end
        else if (PAGE_BITS > PW)
        begin : g_in_wide
            assign in_page = {{(PAGE_BITS - PW){1'b0}}, s_tdata[PW-1:0]};
        end
        else
        begin : g_in_narrow
            assign in_page = s_tdata[PAGE_BITS-1:0];
        end
    endgenerate

    assign s_tready = !busy_reg;
    assign s_fire   = s_tvalid && s_tready;
    // update cycle runs once the result register is free or being emptied
    assign work     = busy_reg && (!out_valid_reg || m_tready);

    always_comb
    begin
        busy_next = busy_reg;
        page_next = page_reg;
        wr_next   = wr_reg;
        if (s_fire)
        begin
            busy_next = 1'b1;
            page_next = in_page;
            wr_next   = s_tuser;
        end
        else if (work)
        begin
            busy_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // policy decode and occupancy
    // ------------------------------------------------------------------------
    logic [CW-1:0]  occ_reg, occ_next;
    logic [KW-1:0]  cap_ext;
    logic [KW-1:0]  cap_eff;
    logic [KW-1:0]  occ_ext;
    logic           is_lru;
    logic           is_sc;
    logic           hit;
    logic           evict;
    logic           any_unref;
    logic           sc_find;
    logic           head_victim;
    pgr_pkg::cell_ctrl_t ctrl;

    assign is_lru  = (mode_reg == pgr_pkg::POLICY_LRU);
    assign is_sc   = (mode_reg == pgr_pkg::POLICY_SC);
    assign cap_ext = KW'(cap_reg);
    assign occ_ext = KW'(occ_reg);

    // capacity 0 acts as one frame, values above the cell count as all cells
    always_comb
    begin
        if (cap_ext == '0)
        begin
            cap_eff = KW'(1);
        end
        else if (cap_ext > KW'(FRAMES))
        begin
            cap_eff = KW'(FRAMES);
        end
        else
        begin
            cap_eff = cap_ext;
        end
    end

    assign evict       = !hit && (occ_ext >= cap_eff);
    assign sc_find     = evict && is_sc && any_unref;
    // FIFO, LRU and an all-referenced second chance scan evict the oldest
    assign head_victim = evict && !sc_find;

    logic new_dirty_sel;
    logic new_ref_sel;

    always_comb
    begin
        ctrl.en        = work;
        ctrl.wr        = wr_reg;
        ctrl.hit       = hit;
        ctrl.remove    = evict || (hit && is_lru);
        ctrl.append    = !hit && !evict;
        ctrl.sc_mark   = hit && is_sc;
        ctrl.sc_find   = sc_find;
        ctrl.sc_clear  = evict && is_sc;
        ctrl.new_dirty = hit ? (new_dirty_sel || wr_reg) : wr_reg;
        ctrl.new_ref   = hit ? new_ref_sel : 1'b0;
    end

    always_comb
    begin
        occ_next = occ_reg;
        if (work && ctrl.append)
        begin
            occ_next = occ_reg + CW'(1);
        end
    end

    // ------------------------------------------------------------------------
    // frame chain, cell 0 holds the oldest page
    // ------------------------------------------------------------------------
    logic                 c_valid [FRAMES];
    logic [PAGE_BITS-1:0] c_page  [FRAMES];
    logic                 c_dirty [FRAMES];
    logic                 c_refd  [FRAMES];
    logic                 c_hit   [FRAMES];
    logic                 c_rm    [FRAMES];
    logic                 hit_link   [FRAMES+1];
    logic                 vic_link   [FRAMES+1];
    logic                 after_link [FRAMES+1];

    assign hit_link[0]   = 1'b0;
    assign vic_link[0]   = 1'b0;
    assign after_link[0] = head_victim;
    assign hit           = hit_link[FRAMES];
    assign any_unref     = vic_link[FRAMES];

    genvar gi;
    generate
        for (gi = 0; gi < FRAMES; gi++)
        begin : g_cell
            logic                 up_valid;
            logic [PAGE_BITS-1:0] up_page;
            logic                 up_dirty;
            logic                 up_refd;
            logic                 prev_valid;

            if (gi == FRAMES - 1)
            begin : g_top
                assign up_valid = 1'b0;
                assign up_page  = '0;
                assign up_dirty = 1'b0;
                assign up_refd  = 1'b0;
            end
            else
            begin : g_mid
                assign up_valid = c_valid[gi+1];
                assign up_page  = c_page[gi+1];
                assign up_dirty = c_dirty[gi+1];
                assign up_refd  = c_refd[gi+1];
            end

            if (gi == 0)
            begin : g_head
                assign prev_valid = 1'b1;
            end
            else
            begin : g_rest
                assign prev_valid = c_valid[gi-1];
            end

            pgr_cell #(
                .PAGE_BITS (PAGE_BITS)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .new_page   (page_reg),
                .up_valid   (up_valid),
                .up_page    (up_page),
                .up_dirty   (up_dirty),
                .up_refd    (up_refd),
                .prev_valid (prev_valid),
                .hit_in     (hit_link[gi]),
                .hit_out    (hit_link[gi+1]),
                .vic_in     (vic_link[gi]),
                .vic_out    (vic_link[gi+1]),
                .after_in   (after_link[gi]),
                .after_out  (after_link[gi+1]),
                .hit_here   (c_hit[gi]),
                .rm_here    (c_rm[gi]),
                .valid      (c_valid[gi]),
                .page       (c_page[gi]),
                .dirty      (c_dirty[gi]),
                .refd       (c_refd[gi])
            );
        end
    endgenerate

    // pick the hit entry's bits and the victim's page out of the chain
    logic [PAGE_BITS-1:0] vic_page;
    logic                 vic_dirty;

    always_comb
    begin
        new_dirty_sel = 1'b0;
        new_ref_sel   = 1'b0;
        vic_page      = '0;
        vic_dirty     = 1'b0;
        for (int i = 0; i < FRAMES; i++)
        begin
            new_dirty_sel = new_dirty_sel || (c_hit[i] && c_dirty[i]);
            new_ref_sel   = new_ref_sel || (c_hit[i] && c_refd[i]);
            if (sc_find && c_rm[i])
            begin
                vic_page  = vic_page | c_page[i];
                vic_dirty = vic_dirty || c_dirty[i];
            end
        end
        if (head_victim)
        begin
            vic_page  = c_page[0];
            vic_dirty = c_dirty[0];
        end
    end

    // ------------------------------------------------------------------------
    // cost, totals and result register
    // ------------------------------------------------------------------------
    logic [PW-1:0]                ev_page;
    logic                         ev_dirty;
    logic [pgr_pkg::COST_W-1:0]   cost;
    logic [TW:0]                  sum_wide;
    logic [TW-1:0]                total_reg, total_next;
    logic [FW-1:0]                faults_reg, faults_next;
    logic [OW-1:0]                result;
    logic [119:0]                 out_data_reg, out_data_next;

    generate
        if (PAGE_BITS == PW)
        begin : g_ev_eq
            assign ev_page = evict ? vic_page : '0;
        end
        else if (PAGE_BITS > PW)
        begin : g_ev_wide
            assign ev_page = evict ? vic_page[PW-1:0] : '0;
        end
        else
        begin : g_ev_narrow
            assign ev_page = evict ? {{(PW - PAGE_BITS){1'b0}}, vic_page} : '0;
        end
    endgenerate

    assign ev_dirty = evict && vic_dirty;
    assign cost     = (hit ? '0 : pgr_pkg::FAULT_COST) + (ev_dirty ? pgr_pkg::DIRTY_COST : '0);
    assign sum_wide = {1'b0, total_reg} + (TW+1)'(cost);

    always_comb
    begin
        total_next  = total_reg;
        faults_next = faults_reg;
        if (work)
        begin
            // carry out means the sum passed the top of the range
            total_next = sum_wide[TW] ? {TW{1'b1}} : sum_wide[TW-1:0];
            if (!hit && (faults_reg != {FW{1'b1}}))
            begin
                faults_next = faults_reg + FW'(1);
            end
        end
    end

    assign result = {faults_next, total_next, cost, ev_dirty, ev_page, evict, hit};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (work)
        begin
            out_valid_next = 1'b1;
            out_data_next  = 120'(result);
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ------------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= pgr_pkg::POLICY_FIFO;
            cap_reg       <= pgr_pkg::CAP_RESET;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            occ_reg       <= '0;
            total_reg     <= '0;
            faults_reg    <= '0;
        end
        else
        begin
            mode_reg      <= mode_next;
            cap_reg       <= cap_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            occ_reg       <= occ_next;
            total_reg     <= total_next;
            faults_reg    <= faults_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg     <= page_next;
        wr_reg       <= wr_next;
        out_data_reg <= out_data_next;
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    logic [FRAMES-1:0] valid_vec;

    always_comb
    begin
        for (int i = 0; i < FRAMES; i++)
        begin
            valid_vec[i] = c_valid[i];
        end
    end

`ifndef ASSERT_OFF
    // occupancy counter tracks the filled cells of the chain
    a_occ_match: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == occ_reg)
        else $error("occupancy count differs from filled cells");

    // a hit never reports an eviction
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |-> !m_tdata[1])
        else $error("hit transaction reports an eviction");

    // a fault with all frames in use always evicts
    a_full_evicts: assert property (@(posedge clk) disable iff (!rst_n)
        (work && !hit && (occ_ext >= cap_eff)) |=> (m_tvalid && m_tdata[1]))
        else $error("fault on a full set did not evict");

    // fault total never goes down
    a_faults_mono: assert property (@(posedge clk) disable iff (!rst_n)
        work |=> (faults_reg >= $past(faults_reg)))
        else $error("fault total decreased");
`endif

endmodule

>>> sim/page_replacement_policy_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// page_replacement_policy_tb
// self-checking bench for the page replacement block: a short scripted walk
// through reset values, field extremes, every policy and the capacity corner
// cases, then random phases of access transactions against a predictor
// ----------------------------------------------------------------------------
module page_replacement_policy_tb;

    localparam int MODE_W   = pgr_pkg::MODE_W;
    localparam int CAP_W    = pgr_pkg::CAP_W;
    localparam int PAGE_W   = pgr_pkg::PAGE_W;
    localparam int COST_W   = pgr_pkg::COST_W;
    localparam int TOTAL_W  = pgr_pkg::TOTAL_W;
    localparam int FAULTS_W = pgr_pkg::FAULTS_W;

    localparam int FRAME_SLOTS = 16;
    localparam int STALL_LIMIT = 5000;        // cycles with no transaction at all
    localparam int HOLD_CYCLES = 400;         // one long back-pressure window
    localparam int RANDOM_PAGES = 1950;
    localparam int EXPECT_DEPTH = 4096;       // ring of expected results
    localparam int PLAN_DEPTH = 64;
    localparam logic [MODE_W-1:0] POLICY_UNUSED = 2'd3;   // decodes as FIFO
    localparam logic [PAGE_W-1:0] MAX_PAGE = {PAGE_W{1'b1}};
    localparam logic [TOTAL_W-1:0] COST_CEIL = {TOTAL_W{1'b1}};

    // one result transaction, field by field
    typedef struct packed {
        logic                hit;
        logic                ev_valid;
        logic [PAGE_W-1:0]   ev_page;
        logic                ev_dirty;
        logic [COST_W-1:0]   cost;
        logic [TOTAL_W-1:0]  total_cost;
        logic [FAULTS_W-1:0] total_faults;
    } outcome_t;

    typedef enum logic {ROW_ACCESS, ROW_REG} row_kind_t;

    // scripted step: either an access or a register write
    typedef struct packed {
        row_kind_t           kind;
        logic                reg_sel;   // register for a write row
        logic [PAGE_W-1:0]   page;      // page, or register value
        logic                wr;
        logic                typed;     // fields below hold the known answer
        logic                t_hit;
        logic                t_ev_valid;
        logic [PAGE_W-1:0]   t_ev_page;
        logic                t_ev_dirty;
        logic [COST_W-1:0]   t_cost;
    } plan_row_t;

    // ------------------------------------------------------------------------
    // dut signals, all known from time zero
    // ------------------------------------------------------------------------
    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [23:0]  s_tdata = '0;     // [20:0] page_number, [23:21] zero
    logic         s_tuser = 1'b0;   // [0] is_write
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [119:0] m_tdata;          // [0] hit, [1] evicted_valid, [22:2] evicted_page,
                                    // [23] evicted_dirty, [33:24] access_cost,
                                    // [81:34] total_cost, [113:82] total_faults
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    page_replacement_policy DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // predictor state: resident pages oldest first, plus running totals
    // ------------------------------------------------------------------------
    logic [PAGE_W-1:0]   slot_page [FRAME_SLOTS];
    logic                slot_dirty [FRAME_SLOTS];
    logic                slot_ref [FRAME_SLOTS];
    int                  slots_used = 0;
    logic [TOTAL_W-1:0]  cost_total = '0;
    logic [FAULTS_W-1:0] fault_total = '0;
    logic [MODE_W-1:0]   policy_reg = pgr_pkg::POLICY_FIFO;
    logic [CAP_W-1:0]    capacity_reg = pgr_pkg::CAP_RESET;

    outcome_t  expect_store [EXPECT_DEPTH];   // expected results, oldest at expect_rd
    int        expect_wr = 0;
    int        expect_rd = 0;
    plan_row_t test_plan [PLAN_DEPTH];
    int        plan_len = 0;
    int        pages_sent = 0;
    int        outcomes_taken = 0;
    int        mismatches = 0;
    bit        steady = 1'b0;          // both sides run without idling
    bit        held_off = 1'b0;

    // remove one entry and close the gap so the order is kept
    function automatic void drop_slot(input int v);
        for (int i = v; i + 1 < slots_used; i++) begin
            slot_page[i]  = slot_page[i + 1];
            slot_dirty[i] = slot_dirty[i + 1];
            slot_ref[i]   = slot_ref[i + 1];
        end
        slots_used--;
    endfunction

    // new entry always lands at the young end
    function automatic void push_slot(input logic [PAGE_W-1:0] page, input logic dirty,
                                      input logic referenced);
        if (slots_used < FRAME_SLOTS) begin
            slot_page[slots_used]  = page;
            slot_dirty[slots_used] = dirty;
            slot_ref[slots_used]   = referenced;
            slots_used++;
        end
    endfunction

    // expected result goes to the young end of the ring
    function automatic void store_outcome(input outcome_t o);
        expect_store[expect_wr % EXPECT_DEPTH] = o;
        expect_wr++;
    endfunction

    // scripted step goes to the end of the plan
    function automatic void add_row(input plan_row_t r);
        if (plan_len < PLAN_DEPTH) begin
            test_plan[plan_len] = r;
            plan_len++;
        end
    endfunction

    // look the page up, apply the policy and charge the access
    function automatic outcome_t replace_and_charge(input logic [PAGE_W-1:0] page,
                                                    input logic wr);
        outcome_t o;
        int       found;
        int       victim;
        int       limit;
        logic     keep_dirty;
        logic     keep_ref;
        o = '0;
        // capacity 0 acts as one frame, anything above the array as all frames
        limit = (capacity_reg == 0) ? 1 :
                (capacity_reg > FRAME_SLOTS) ? FRAME_SLOTS : int'(capacity_reg);
        found = -1;
        for (int i = 0; i < slots_used; i++)
            if (found < 0 && slot_page[i] == page)
                found = i;
        if (found >= 0) begin
            o.hit = 1'b1;
            slot_dirty[found] = slot_dirty[found] | wr;
            if (policy_reg == pgr_pkg::POLICY_LRU) begin
                // hit moves to the young end, flags travel with it
                keep_dirty = slot_dirty[found];
                keep_ref   = slot_ref[found];
                drop_slot(found);
                push_slot(page, keep_dirty, keep_ref);
            end
            else if (policy_reg == pgr_pkg::POLICY_SC)
                slot_ref[found] = 1'b1;
        end
        else begin
            o.cost = pgr_pkg::FAULT_COST;
            // occupancy may sit above a lowered capacity: still one victim only
            if (slots_used >= limit && slots_used > 0) begin
                victim = -1;
                if (policy_reg == pgr_pkg::POLICY_SC)
                    for (int i = 0; i < slots_used; i++)
                        if (victim < 0) begin
                            if (!slot_ref[i])
                                victim = i;
                            else
                                slot_ref[i] = 1'b0;
                        end
                // all referenced (or FIFO / LRU / unused code): oldest goes
                if (victim < 0)
                    victim = 0;
                o.ev_valid = 1'b1;
                o.ev_page  = slot_page[victim];
                o.ev_dirty = slot_dirty[victim];
                if (o.ev_dirty)
                    o.cost = o.cost + pgr_pkg::DIRTY_COST;
                drop_slot(victim);
            end
            push_slot(page, wr, 1'b0);
            if (fault_total != {FAULTS_W{1'b1}})
                fault_total = fault_total + 1'b1;
        end
        if (cost_total > COST_CEIL - TOTAL_W'(o.cost))
            cost_total = COST_CEIL;
        else
            cost_total = cost_total + TOTAL_W'(o.cost);
        o.total_cost   = cost_total;
        o.total_faults = fault_total;
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // scripted rows
    // ------------------------------------------------------------------------
    function automatic plan_row_t acc_row(input logic [PAGE_W-1:0] page, input logic wr);
        plan_row_t r;
        r = '0;
        r.kind = ROW_ACCESS;
        r.page = page;
        r.wr   = wr;
        return r;
    endfunction

    function automatic plan_row_t acc_row_known(input logic [PAGE_W-1:0] page,
                                                input logic wr, input logic hit,
                                                input logic ev_valid,
                                                input logic [PAGE_W-1:0] ev_page,
                                                input logic ev_dirty,
                                                input logic [COST_W-1:0] cost);
        plan_row_t r;
        r = acc_row(page, wr);
        r.typed      = 1'b1;
        r.t_hit      = hit;
        r.t_ev_valid = ev_valid;
        r.t_ev_page  = ev_page;
        r.t_ev_dirty = ev_dirty;
        r.t_cost     = cost;
        return r;
    endfunction

    function automatic plan_row_t reg_row(input logic sel, input logic [PAGE_W-1:0] value);
        plan_row_t r;
        r = '0;
        r.kind    = ROW_REG;
        r.reg_sel = sel;
        r.page    = value;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // drivers, all called and returning at a falling edge
    // ------------------------------------------------------------------------

    // present one access transaction, wait until it is taken, predict its result
    task automatic offer_page(input logic [PAGE_W-1:0] page, input logic wr,
                              output outcome_t predicted);
        steady = (pages_sent >= 700 && pages_sent < 1100);
        while (!steady && $urandom_range(99) < 17) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, page};
        s_tuser  <= wr;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = replace_and_charge(page, wr);
        pages_sent++;
        @(negedge clk);
    endtask

    // let every expected result come home before touching registers
    task automatic drain_outcomes();
        s_tvalid <= 1'b0;
        while (expect_wr != expect_rd)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    // write a register, then read it back
    task automatic write_register(input logic sel, input logic [31:0] value);
        logic [31:0] stored;
        stored = (sel == pgr_pkg::REG_POLICY) ? {30'b0, value[MODE_W-1:0]} :
                                                {27'b0, value[CAP_W-1:0]};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (sel == pgr_pkg::REG_POLICY)
            policy_reg = stored[MODE_W-1:0];
        else
            capacity_reg = stored[CAP_W-1:0];
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== stored) begin
            $error("register %0d readback mismatch: expected %0d, got %0d", sel, stored,
                   prdata);
            mismatches++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        outcome_t          fresh;
        logic [MODE_W-1:0] policy;
        logic [CAP_W-1:0]  capacity;
        logic [PAGE_W-1:0] hot_base;
        logic [PAGE_W-1:0] page;
        logic [PAGE_W-1:0] last_page;
        logic              wr;
        int                span;
        int                pick;

        // reset values first: FIFO, 16 frames
        add_row(acc_row_known(21'd0, 1'b0, 1'b0, 1'b0, 21'd0, 1'b0, 10'd100));
        add_row(acc_row_known(MAX_PAGE, 1'b1, 1'b0, 1'b0, 21'd0, 1'b0, 10'd100));
        add_row(acc_row_known(21'd0, 1'b1, 1'b1, 1'b0, 21'd0, 1'b0, 10'd0));
        // full at two frames: dirty victim costs the write back
        add_row(reg_row(pgr_pkg::REG_CAPACITY, 21'd2));
        add_row(acc_row_known(21'd5, 1'b0, 1'b0, 1'b1, 21'd0, 1'b1, 10'd600));
        // capacity zero acts as one, below current occupancy
        add_row(reg_row(pgr_pkg::REG_CAPACITY, 21'd0));
        add_row(acc_row_known(21'd7, 1'b0, 1'b0, 1'b1, MAX_PAGE, 1'b1, 10'd600));
        // LRU, capacity above the array
        add_row(reg_row(pgr_pkg::REG_POLICY, PAGE_W'(pgr_pkg::POLICY_LRU)));
        add_row(reg_row(pgr_pkg::REG_CAPACITY, 21'd31));
        add_row(acc_row(21'd5, 1'b0));
        add_row(acc_row(21'h155555, 1'b1));
        add_row(reg_row(pgr_pkg::REG_CAPACITY, 21'd2));
        add_row(acc_row(21'd9, 1'b0));
        // second chance: skip referenced pages, then the all-referenced case
        add_row(reg_row(pgr_pkg::REG_POLICY, PAGE_W'(pgr_pkg::POLICY_SC)));
        add_row(acc_row(21'd5, 1'b0));
        add_row(acc_row(21'd9, 1'b0));
        add_row(acc_row(21'h0AAAAA, 1'b0));
        add_row(acc_row(21'd5, 1'b1));
        add_row(acc_row(21'h0AAAAA, 1'b0));
        add_row(acc_row(21'd11, 1'b0));
        // unused policy code falls back to FIFO
        add_row(reg_row(pgr_pkg::REG_POLICY, PAGE_W'(POLICY_UNUSED)));
        add_row(reg_row(pgr_pkg::REG_CAPACITY, 21'd1));
        add_row(acc_row(21'd11, 1'b0));
        add_row(acc_row(21'd13, 1'b0));
        add_row(reg_row(pgr_pkg::REG_POLICY, PAGE_W'(pgr_pkg::POLICY_FIFO)));
        add_row(reg_row(pgr_pkg::REG_CAPACITY, 21'd16));

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < plan_len; i++) begin
            if (test_plan[i].kind == ROW_REG) begin
                drain_outcomes();
                write_register(test_plan[i].reg_sel, {11'b0, test_plan[i].page});
            end
            else begin
                offer_page(test_plan[i].page, test_plan[i].wr, fresh);
                // known answers replace the per-access fields, totals stay predicted
                if (test_plan[i].typed) begin
                    fresh.hit      = test_plan[i].t_hit;
                    fresh.ev_valid = test_plan[i].t_ev_valid;
                    fresh.ev_page  = test_plan[i].t_ev_page;
                    fresh.ev_dirty = test_plan[i].t_ev_dirty;
                    fresh.cost     = test_plan[i].t_cost;
                end
                store_outcome(fresh);
            end
        end

        // random phases: new setting, then a hot working set around the capacity
        hot_base  = PAGE_W'($urandom_range(MAX_PAGE));
        last_page = hot_base;
        while (pages_sent < RANDOM_PAGES) begin
            policy = MODE_W'($urandom_range(3));
            case ($urandom_range(9))
                0:       capacity = CAP_W'(0);
                1:       capacity = CAP_W'(1);
                2:       capacity = CAP_W'(16);
                3:       capacity = CAP_W'($urandom_range(31, 17));
                default: capacity = CAP_W'($urandom_range(16, 1));
            endcase
            drain_outcomes();
            write_register(pgr_pkg::REG_POLICY, 32'(policy));
            write_register(pgr_pkg::REG_CAPACITY, 32'(capacity));
            span = (capacity == 0) ? 1 : (capacity > 16) ? 16 : int'(capacity);
            span = span + int'($urandom_range(3)) - 1;
            if ($urandom_range(1))
                hot_base = PAGE_W'($urandom_range(MAX_PAGE));
            repeat ($urandom_range(160, 40)) begin
                pick = $urandom_range(99);
                if (pick < 80)
                    page = hot_base ^ PAGE_W'($urandom_range(span));
                else if (pick < 90)
                    page = PAGE_W'($urandom_range(MAX_PAGE));
                else if (pick < 95)
                    page = pick[0] ? MAX_PAGE : '0;
                else
                    page = last_page;
                wr = ($urandom_range(99) < 30);
                offer_page(page, wr, fresh);
                store_outcome(fresh);
                last_page = page;
            end
        end

        drain_outcomes();
        repeat (10) @(negedge clk);
        if (mismatches == 0 && expect_wr == expect_rd)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // result side back-pressure: random idling, one long hold while the
    // sender keeps offering so the block fills up and stalls its input
    // ------------------------------------------------------------------------
    initial begin : result_sink
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (!held_off && outcomes_taken >= 300 && s_tvalid) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                held_off = 1'b1;
            end
            else
                m_tready <= steady || ($urandom_range(99) >= 17);
        end
    end

    // ------------------------------------------------------------------------
    // result checker: every taken transaction against the oldest expectation
    // ------------------------------------------------------------------------
    task automatic compare_field(input string field, input logic [63:0] want,
                                 input logic [63:0] seen);
        if (want !== seen) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, seen);
            mismatches++;
        end
    endtask

    outcome_t oldest;

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            if (expect_wr == expect_rd) begin
                $error("result transaction with nothing expected");
                mismatches++;
            end
            else begin
                oldest = expect_store[expect_rd % EXPECT_DEPTH];
                expect_rd++;
                compare_field("hit", 64'(oldest.hit), 64'(m_tdata[0]));
                compare_field("evicted_valid", 64'(oldest.ev_valid), 64'(m_tdata[1]));
                compare_field("evicted_page", 64'(oldest.ev_page), 64'(m_tdata[22:2]));
                compare_field("evicted_dirty", 64'(oldest.ev_dirty), 64'(m_tdata[23]));
                compare_field("access_cost", 64'(oldest.cost), 64'(m_tdata[33:24]));
                compare_field("total_cost", 64'(oldest.total_cost), 64'(m_tdata[81:34]));
                compare_field("total_faults", 64'(oldest.total_faults),
                              64'(m_tdata[113:82]));
            end
            outcomes_taken++;
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without any transaction on either stream or the port
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles = 0;
        else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

endmodule
